// File: src/pmue_pkg.sv
// Package for the pheromone matrix update engine: field widths, register
// reset values, opcode and command codes, the queued command and FSM types.
// No dependencies; every other file but pmue_ram imports it.
`default_nettype none

package pmue_pkg;

  localparam int CITY_W     = 6;
  localparam int OPCODE_W   = 3;
  localparam int AMOUNT_W   = 32;
  localparam int READ_W     = 32;
  localparam int RETAIN_W   = 16;
  localparam int BOUND_W    = 32;
  localparam int CITIES_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [RETAIN_W-1:0] RETAIN_RST  = 16'hFFFF;
  localparam logic [BOUND_W-1:0]  FLOOR_RST   = 32'h0000_0000;
  localparam logic [BOUND_W-1:0]  CEILING_RST = 32'hFFFF_FFFF;
  localparam logic [CITIES_W-1:0] CITIES_RST  = 7'd64;

  // The command queue depth must be a power of two so the pointers wrap.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_DEPOSIT   = 3'd0,
    OP_EVAPORATE = 3'd1,
    OP_CLAMP     = 3'd2,
    OP_READ      = 3'd3,
    OP_FILL      = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RETAIN  = 2'd0,
    CFG_FLOOR   = 2'd1,
    CFG_CEILING = 2'd2,
    CFG_CITIES  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_DEPOSIT,
    CMD_EVAPORATE,
    CMD_CLAMP,
    CMD_READ,
    CMD_FILL
  } cmd_e;

  // One classified word. For a read, e0_a/e0_b carry row and column.
  typedef struct packed {
    cmd_e                kind;
    logic                bad;
    logic                e0_vld;
    logic [CITY_W-1:0]   e0_a;
    logic [CITY_W-1:0]   e0_b;
    logic                e1_vld;
    logic [CITY_W-1:0]   e1_a;
    logic [CITY_W-1:0]   e1_b;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [RETAIN_W-1:0] retain;
    logic [BOUND_W-1:0]  tau_floor;
    logic [BOUND_W-1:0]  tau_ceiling;
  } sweep_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_READ,
    ST_RDATA,
    ST_SWEEP,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: src/pmue_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pmue_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/pmue_cmd_fifo.sv
// Short command queue between the front classifier and the back executor.
// Depends on pmue_pkg for cmd_t and the queue depth.
`default_nettype none

module pmue_cmd_fifo import pmue_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_data_o
);

  cmd_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  push;
  logic                  pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/pmue_front.sv
// Front end: accepts input words, checks indices, tracks the open tour and
// turns each word into one command for the queue. Depends on pmue_pkg.
`default_nettype none

module pmue_front import pmue_pkg::*; #(
  parameter int MAX_CITIES = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [OPCODE_W-1:0]               opcode_i,
  input  wire logic [CITY_W-1:0]                 city_i,
  input  wire logic [CITY_W-1:0]                 column_i,
  input  wire logic                              tour_end_i,
  input  wire logic [AMOUNT_W-1:0]               amount_i,
  input  wire logic [$clog2(MAX_CITIES+1)-1:0]   n_i,
  output logic                                   cmd_valid_o,
  output cmd_t                                   cmd_o,
  input  wire logic                              cmd_ready_i
);

  localparam int NW   = $clog2(MAX_CITIES + 1);
  localparam int CMPW = (NW > CITY_W) ? NW : CITY_W;

  logic [CITY_W-1:0] first_q, first_d;
  logic [CITY_W-1:0] prev_q, prev_d;
  logic              open_q, open_d;
  logic              accept;
  logic              city_ok, column_ok, prev_ok, first_ok;
  logic [CITY_W-1:0] new_first;
  logic              new_first_ok;
  logic              tour_step;
  cmd_t              cmd;

  function automatic logic below_n(input logic [CITY_W-1:0] x,
                                   input logic [NW-1:0] n);
    return CMPW'(x) < CMPW'(n);
  endfunction

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;
  assign cmd_o       = cmd;

  assign city_ok   = below_n(city_i, n_i);
  assign column_ok = below_n(column_i, n_i);
  assign prev_ok   = below_n(prev_q, n_i);
  assign first_ok  = below_n(first_q, n_i);

  // With no tour open this city starts one and becomes its first city.
  assign new_first    = open_q ? first_q : city_i;
  assign new_first_ok = open_q ? first_ok : 1'b1;

  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_NOP;
    cmd.amount = amount_i;
    tour_step  = 1'b0;
    case (op_e'(opcode_i))
      OP_DEPOSIT: begin
        if (!city_ok) begin
          cmd.bad = 1'b1;
        end else begin
          tour_step  = 1'b1;
          cmd.kind   = CMD_DEPOSIT;
          cmd.e0_vld = open_q && prev_ok;
          cmd.e0_a   = prev_q;
          cmd.e0_b   = city_i;
          cmd.e1_vld = tour_end_i && new_first_ok;
          cmd.e1_a   = city_i;
          cmd.e1_b   = new_first;
        end
      end
      OP_EVAPORATE: cmd.kind = CMD_EVAPORATE;
      OP_CLAMP:     cmd.kind = CMD_CLAMP;
      OP_READ: begin
        if (city_ok && column_ok) begin
          cmd.kind = CMD_READ;
          cmd.e0_a = city_i;
          cmd.e0_b = column_i;
        end else begin
          cmd.bad = 1'b1;
        end
      end
      OP_FILL:      cmd.kind = CMD_FILL;
      default:      cmd.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    first_d = first_q;
    prev_d  = prev_q;
    open_d  = open_q;
    if (accept && tour_step) begin
      first_d = new_first;
      prev_d  = city_i;
      open_d  = !tour_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      prev_q  <= '0;
      open_q  <= 1'b0;
    end else begin
      first_q <= first_d;
      prev_q  <= prev_d;
      open_q  <= open_d;
    end
  end

endmodule

`default_nettype wire

// File: src/pmue_back.sv
// Back end: executes queued commands against the pheromone table RAM
// (read-modify-write deposits, sweeps, fill, read) and holds the result
// word. Depends on pmue_pkg and pmue_ram.
`default_nettype none

module pmue_back import pmue_pkg::*; #(
  parameter int MAX_CITIES = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cmd_valid_i,
  output logic                                 cmd_ready_o,
  input  wire cmd_t                            cmd_i,
  input  wire logic [$clog2(MAX_CITIES+1)-1:0] n_i,
  input  wire sweep_cfg_t                      sweep_cfg_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [READ_W-1:0]                    read_value_o,
  output logic                                 saturated_o,
  output logic                                 bad_index_o
);

  localparam int CW    = $clog2(MAX_CITIES);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = VALUE_BITS + RETAIN_W;
  localparam int BW    = (VALUE_BITS > BOUND_W) ? VALUE_BITS : BOUND_W;
  localparam int SW    = BW + 1;
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  state_e                state_q, state_d;
  cmd_t                  cmd_q;
  logic [1:0]            slot_q;
  logic                  sat_q;
  logic [NW-1:0]         row_q, col_q;
  logic [AW-1:0]         fill_addr_q;
  logic                  s1_vld_q, s2_vld_q;
  logic [AW-1:0]         s1_addr_q, s2_addr_q;
  logic [PW-1:0]         s2_val_q;
  logic [VALUE_BITS-1:0] lo_q, hi_q;
  logic [READ_W-1:0]     res_val_q;
  logic                  out_valid_q;
  logic [READ_W-1:0]     out_value_q;
  logic                  out_sat_q, out_bad_q;

  logic                  slot_vld;
  logic [CITY_W-1:0]     slot_row, slot_col;
  logic [AW-1:0]         slot_addr;
  logic                  sweep_more;
  logic                  sweep_issue;
  logic                  cmd_take;
  logic                  out_load;
  logic                  ram_re, ram_we;
  logic [AW-1:0]         ram_raddr, ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0]         sum;
  logic                  sum_ovf;
  logic [VALUE_BITS-1:0] sum_val;
  logic [VALUE_BITS-1:0] fill_val;
  logic [PW-1:0]         product;
  logic [VALUE_BITS-1:0] raised, clamped;

  function automatic logic [VALUE_BITS-1:0] limit(input logic [BOUND_W-1:0] x);
    logic [BW-1:0] xe;
    xe = BW'(x);
    return (xe < BW'(VMAX)) ? VALUE_BITS'(xe) : VMAX;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CITY_W-1:0] row,
                                            input logic [CITY_W-1:0] col);
    return {CW'(row), CW'(col)};
  endfunction

  pmue_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Four updates per deposit: both directions of the step edge, then both
  // directions of the closing edge. A self edge hits one entry twice.
  always_comb begin
    case (slot_q)
      2'd0: begin
        slot_vld = cmd_q.e0_vld;
        slot_row = cmd_q.e0_a;
        slot_col = cmd_q.e0_b;
      end
      2'd1: begin
        slot_vld = cmd_q.e0_vld;
        slot_row = cmd_q.e0_b;
        slot_col = cmd_q.e0_a;
      end
      2'd2: begin
        slot_vld = cmd_q.e1_vld;
        slot_row = cmd_q.e1_a;
        slot_col = cmd_q.e1_b;
      end
      default: begin
        slot_vld = cmd_q.e1_vld;
        slot_row = cmd_q.e1_b;
        slot_col = cmd_q.e1_a;
      end
    endcase
  end

  assign slot_addr = addr_of(slot_row, slot_col);

  assign sum      = SW'(ram_rdata) + SW'(cmd_q.amount);
  assign sum_ovf  = |sum[SW-1:VALUE_BITS];
  assign sum_val  = sum_ovf ? VMAX : sum[VALUE_BITS-1:0];
  assign fill_val = limit(cmd_q.amount);

  assign product = PW'(ram_rdata) * PW'(sweep_cfg_i.retain);
  assign raised  = (ram_rdata < lo_q) ? lo_q : ram_rdata;
  assign clamped = (raised > hi_q) ? hi_q : raised;

  assign sweep_more = (row_q < n_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_DEPOSIT:   state_d = ST_RMW_RD;
            CMD_EVAPORATE: state_d = ST_SWEEP;
            CMD_CLAMP:     state_d = ST_SWEEP;
            CMD_READ:      state_d = ST_READ;
            CMD_FILL:      state_d = ST_FILL;
            default:       state_d = ST_DONE;
          endcase
        end
      end
      ST_RMW_RD: begin
        if (slot_vld) begin
          state_d = ST_RMW_WR;
        end else if (slot_q == 2'd3) begin
          state_d = ST_DONE;
        end
      end
      ST_RMW_WR: state_d = (slot_q == 2'd3) ? ST_DONE : ST_RMW_RD;
      ST_READ:   state_d = ST_RDATA;
      ST_RDATA:  state_d = ST_DONE;
      ST_SWEEP: begin
        if (!sweep_more) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        if (fill_addr_q == '1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: RAM control, queue pop, result load.
  always_comb begin
    cmd_take    = 1'b0;
    out_load    = 1'b0;
    sweep_issue = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = slot_addr;
    ram_we      = 1'b0;
    ram_waddr   = slot_addr;
    ram_wdata   = sum_val;
    case (state_q)
      ST_IDLE:   cmd_take = cmd_valid_i;
      ST_RMW_RD: ram_re = slot_vld;
      ST_RMW_WR: ram_we = 1'b1;
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(cmd_q.e0_a, cmd_q.e0_b);
      end
      ST_SWEEP: begin
        sweep_issue = sweep_more;
        ram_re      = sweep_more;
        ram_raddr   = {row_q[CW-1:0], col_q[CW-1:0]};
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr_q;
        ram_wdata = fill_val;
      end
      ST_DONE:   out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
    // Sweep write-back follows the reads through the s1 and s2 stage registers.
    if (s2_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = s2_addr_q;
      ram_wdata = s2_val_q[PW-1:RETAIN_W];
    end
  end

  assign cmd_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      sat_q       <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      fill_addr_q <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= sweep_issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_take) begin
        slot_q      <= '0;
        sat_q       <= 1'b0;
        row_q       <= '0;
        col_q       <= '0;
        fill_addr_q <= '0;
      end
      if (state_q == ST_RMW_RD && !slot_vld) begin
        slot_q <= slot_q + 2'd1;
      end
      if (state_q == ST_RMW_WR) begin
        slot_q <= slot_q + 2'd1;
        sat_q  <= sat_q || sum_ovf;
      end
      if (sweep_issue) begin
        if (col_q + NW'(1) == n_i) begin
          col_q <= '0;
          row_q <= row_q + NW'(1);
        end else begin
          col_q <= col_q + NW'(1);
        end
      end
      if (state_q == ST_FILL) begin
        fill_addr_q <= fill_addr_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      cmd_q <= cmd_i;
      lo_q  <= limit(sweep_cfg_i.tau_floor);
      hi_q  <= limit(sweep_cfg_i.tau_ceiling);
    end
    s1_addr_q <= ram_raddr;
    s2_addr_q <= s1_addr_q;
    // Clamp results sit in the upper part so both sweeps write the same bits.
    if (cmd_q.kind == CMD_EVAPORATE) begin
      s2_val_q <= product;
    end else begin
      s2_val_q <= {clamped, RETAIN_W'(0)};
    end
    if (state_q == ST_RDATA) begin
      res_val_q <= READ_W'(ram_rdata);
    end
    if (out_load) begin
      out_value_q <= (cmd_q.kind == CMD_READ) ? res_val_q : '0;
      out_sat_q   <= (cmd_q.kind == CMD_DEPOSIT) && sat_q;
      out_bad_q   <= cmd_q.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign saturated_o  = out_sat_q;
  assign bad_index_o  = out_bad_q;

endmodule

`default_nettype wire

// File: src/pheromone_matrix_update_engine.sv
// Top level of the pheromone matrix update engine: configuration registers,
// front classifier, command queue and back executor with the table RAM.
// Depends on pmue_pkg, pmue_front, pmue_cmd_fifo, pmue_back, pmue_ram.
//
//   channel  | handshake              | word
//   ---------+------------------------+-----------------------------------------
//   input    | in_valid_i/in_ready_o  | opcode, city, column, tour_end, amount
//   result   | out_valid_o/out_ready_i| read_value, saturated, bad_index
//   config   | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// Every word yields one result word. The back end works through each word in
// steps set by its kind: a deposit does each of its four entry updates as a
// read-modify-write on the table RAM, which has a registered read, or skips
// it; a read sends the address and then takes the data; an evaporate or clamp
// sweeps n*n entries where n = min(active_cities, MAX_CITIES); a fill writes
// all 2^(2*clog2(MAX_CITIES)) entries. Other words go straight to the result.
// Reset clears control and presets configuration; table undefined until filled.
// A two-word queue lets the input side keep accepting while the back end works,
// and the result register holds a word until taken.
`default_nettype none

module pheromone_matrix_update_engine import pmue_pkg::*; #(
  parameter int MAX_CITIES = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [CITY_W-1:0]     city_i,
  input  wire logic [CITY_W-1:0]     column_i,
  input  wire logic                  tour_end_i,
  input  wire logic [AMOUNT_W-1:0]   amount_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [READ_W-1:0]          read_value_o,
  output logic                       saturated_o,
  output logic                       bad_index_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NW  = $clog2(MAX_CITIES + 1);
  localparam int NCW = (NW > CITIES_W) ? NW : CITIES_W;

  logic [RETAIN_W-1:0] retain_q;
  logic [BOUND_W-1:0]  floor_q;
  logic [BOUND_W-1:0]  ceiling_q;
  logic [CITIES_W-1:0] cities_q;
  logic [NW-1:0]       n;
  sweep_cfg_t          sweep_cfg;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retain_q  <= RETAIN_RST;
      floor_q   <= FLOOR_RST;
      ceiling_q <= CEILING_RST;
      cities_q  <= CITIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RETAIN:  retain_q  <= cfg_data_i[RETAIN_W-1:0];
        CFG_FLOOR:   floor_q   <= cfg_data_i[BOUND_W-1:0];
        CFG_CEILING: ceiling_q <= cfg_data_i[BOUND_W-1:0];
        CFG_CITIES:  cities_q  <= cfg_data_i[CITIES_W-1:0];
        default: ;
      endcase
    end
  end

  // Cities in use, limited to the table size.
  assign n = (NCW'(cities_q) < NCW'(MAX_CITIES)) ? NW'(cities_q) : NW'(MAX_CITIES);

  assign sweep_cfg.retain      = retain_q;
  assign sweep_cfg.tau_floor   = floor_q;
  assign sweep_cfg.tau_ceiling = ceiling_q;

  pmue_front #(
    .MAX_CITIES (MAX_CITIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .city_i      (city_i),
    .column_i    (column_i),
    .tour_end_i  (tour_end_i),
    .amount_i    (amount_i),
    .n_i         (n),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  pmue_cmd_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (cmd_valid),
    .pop_ready_i  (cmd_ready),
    .pop_data_o   (cmd)
  );

  pmue_back #(
    .MAX_CITIES (MAX_CITIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .n_i          (n),
    .sweep_cfg_i  (sweep_cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .saturated_o  (saturated_o),
    .bad_index_o  (bad_index_o)
  );

  // A rejected deposit never touches the table, so it cannot saturate.
  a_sat_excludes_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(saturated_o && bad_index_o))
    else $error("saturated and bad_index set in one result");

  // Only a good read returns a nonzero value.
  a_read_value_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_value_o != '0)) |-> (!saturated_o && !bad_index_o))
    else $error("read value present on a non-read result");

  // The back end is not ready in the cycle after it takes a command.
  a_back_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("back end took two commands in consecutive cycles");

endmodule

`default_nettype wire
